>>> rtl/mroc_pkg.sv
// ----------------------------------------------------------------------------
// mroc_pkg
// Shared types and constants for the merged range overlap classifier.
// ----------------------------------------------------------------------------
package mroc_pkg;

  localparam int MAX_RANGES_DEF = 256;

  localparam int ROW_W  = 21;
  localparam int COL_W  = 15;
  localparam int TYPE_W = 8;

  // merge type codes
  localparam logic [TYPE_W-1:0] TYPE_BOTH_SPAN = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] TYPE_ROW_ONLY  = TYPE_W'(2);

  typedef struct packed {
    logic              start_of_set;
    logic [ROW_W-1:0]  row_start;
    logic [ROW_W-1:0]  row_last;
    logic [COL_W-1:0]  col_start;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_span;
    logic [COL_W-1:0]  col_span;
    logic [TYPE_W-1:0] type_in;
  } in_word_t;

  typedef struct packed {
    logic [TYPE_W-1:0] type_out;
    logic              encapsulated;
    logic              needs_resolve;
    logic              store_full;
  } out_word_t;

  // one stored range
  typedef struct packed {
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
  } range_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/mroc_in_if.sv
// ----------------------------------------------------------------------------
// mroc_in_if
// Valid/ready channel carrying one input range word.
// ----------------------------------------------------------------------------
interface mroc_in_if import mroc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mroc_out_if.sv
// ----------------------------------------------------------------------------
// mroc_out_if
// Valid/ready channel carrying one classification result word.
// ----------------------------------------------------------------------------
interface mroc_out_if import mroc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/merged_range_overlap_classifier.sv
// ----------------------------------------------------------------------------
// merged_range_overlap_classifier
// Classifies merged cell ranges against the ranges seen since start of set.
// ----------------------------------------------------------------------------
// channel   dir  word        handshake
// in_ch     in   in_word_t   valid/ready
// out_ch    out  out_word_t  valid/ready
//
// An item is taken, then the N stored ranges are read (N up to MAX_RANGES),
// one read a cycle on the single read port, the last compare finishes, and
// the result is emitted; an empty store skips the reads, and a hit on entry k
// ends the search early.
// Reset clears the fill count and holds input ready low; no store clearing.
// A result waits in the output register while the next word is taken; a new
// result stalls only if that register is still full.
module merged_range_overlap_classifier import mroc_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mroc_in_if.sink     in_ch,
  mroc_out_if.source  out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mroc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mroc_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

>>> rtl/mroc_ctrl.sv
// ----------------------------------------------------------------------------
// mroc_ctrl
// Sequencer: accept a word, scan the store, then emit the result.
// ----------------------------------------------------------------------------
module mroc_ctrl import mroc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no word is taken while reset is high
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mroc_dp.sv
// ----------------------------------------------------------------------------
// mroc_dp
// Range store, scan pointer, compare logic and output register.
// ----------------------------------------------------------------------------
module mroc_dp import mroc_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CntW = $clog2(MAX_RANGES + 1);
  localparam int IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  range_t store [MAX_RANGES];

  logic [CntW-1:0]   count;
  logic [CntW-1:0]   pos;
  logic              rd_vld;
  range_t            rd_data;
  range_t            cur;
  logic [TYPE_W-1:0] cur_type;
  logic              enc;
  logic              res;

  logic              cont;
  logic              ovl;
  logic              hit;
  logic              issue;
  logic              full;
  logic [ROW_W-1:0]  rs, re;
  logic [COL_W-1:0]  cs, ce;
  logic [TYPE_W-1:0] type_calc;

  // merge type rewrite
  always_comb begin
    type_calc = in_data.type_in;
    if (in_data.row_span > ROW_W'(1) && in_data.col_span > COL_W'(1)) begin
      type_calc = TYPE_BOTH_SPAN;
    end else if (in_data.row_span > ROW_W'(1) && in_data.col_span == '0) begin
      type_calc = TYPE_ROW_ONLY;
    end
  end

  // compare current range with the entry just read
  always_comb begin
    rs   = (cur.r0 > rd_data.r0) ? cur.r0 : rd_data.r0;
    re   = (cur.r1 < rd_data.r1) ? cur.r1 : rd_data.r1;
    cs   = (cur.c0 > rd_data.c0) ? cur.c0 : rd_data.c0;
    ce   = (cur.c1 < rd_data.c1) ? cur.c1 : rd_data.c1;
    cont = cur.r0 >= rd_data.r0 && cur.r1 <= rd_data.r1 &&
           cur.c0 >= rd_data.c0 && cur.c1 <= rd_data.c1;
    ovl  = rs <= re && cs <= ce;
  end

  assign hit   = rd_vld && (cont || ovl);
  assign issue = cmd.scan && !hit && (pos < count);
  assign full  = (count == CntW'(MAX_RANGES));

  assign stat.scan_done = hit || (!rd_vld && !(pos < count));
  assign stat.out_free  = !out_valid || out_ready;

  // store: one read port, one write port, registered read data
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= store[pos[IdxW-1:0]];
    end
    if (cmd.emit && !full) begin
      store[count[IdxW-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pos       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        pos    <= '0;
        rd_vld <= 1'b0;
        if (in_data.start_of_set) begin
          count <= '0;
        end
      end else if (cmd.scan) begin
        rd_vld <= issue;
        if (issue) begin
          pos <= pos + CntW'(1);
        end
      end
      if (cmd.emit && !full) begin
        count <= count + CntW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.r0   <= in_data.row_start;
      cur.r1   <= in_data.row_last;
      cur.c0   <= in_data.col_start;
      cur.c1   <= in_data.col_last;
      cur_type <= type_calc;
      enc      <= 1'b0;
      res      <= 1'b0;
    end else if (cmd.scan && hit) begin
      // first hit decides; contains wins over overlap
      enc <= cont;
      res <= !cont;
    end
    if (cmd.emit) begin
      out_data.type_out      <= cur_type;
      out_data.encapsulated  <= enc;
      out_data.needs_resolve <= res;
      out_data.store_full    <= full;
    end
  end

endmodule
